>>> rtl/zts_pkg.sv
// Package for the zoned track/sector to block translator.
// Holds payload structs, request and image codes, sequencer types and zone tables.
// No dependencies.
`default_nettype none

package zts_pkg;

  localparam logic [1:0] REQ_FWD = 2'd0;
  localparam logic [1:0] REQ_REV = 2'd1;
  localparam logic [1:0] REQ_CNT = 2'd2;

  localparam logic [1:0] IMG_SINGLE = 2'd0;
  localparam logic [1:0] IMG_STD    = 2'd1;
  localparam logic [1:0] IMG_DOUBLE = 2'd2;

  localparam logic [0:0] CFG_IMAGE_TYPE = 1'd0;
  localparam logic [0:0] CFG_MAX_TRACKS = 1'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  track_in;
    logic [7:0]  sector_in;
    logic [10:0] block_in;
  } in_t;

  typedef struct packed {
    logic [10:0] block_out;
    logic [6:0]  track_out;
    logic [4:0]  sector_out;
    logic [4:0]  sectors_on_track;
    logic        bad_address;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       start;
    logic       step;
    logic       fin;
    logic [6:0] idx;
  } ctrl_t;

  // Number of tracks in the zone table of an image type; 0 for no table.
  function automatic logic [6:0] table_len(input logic [1:0] img);
    logic [6:0] len;
    len = 7'd0;
    case (img)
      IMG_SINGLE: len = 7'd35;
      IMG_STD:    len = 7'd42;
      IMG_DOUBLE: len = 7'd70;
      default:    len = 7'd0;
    endcase
    return len;
  endfunction

  // Sectors on a track of the selected zone table.
  function automatic logic [4:0] sec_count(input logic [1:0] img, input logic [6:0] trk);
    logic [4:0] n;
    logic [6:0] t;
    n = 5'd0;
    // second side repeats the standard zones
    t = (img == IMG_DOUBLE && trk > 7'd35) ? trk - 7'd35 : trk;
    if (trk == 7'd0) begin
      n = 5'd0;
    end else if (img == IMG_SINGLE) begin
      if (t <= 7'd17)      n = 5'd21;
      else if (t <= 7'd24) n = 5'd20;
      else if (t <= 7'd30) n = 5'd18;
      else if (t <= 7'd35) n = 5'd17;
    end else if (img == IMG_STD) begin
      if (t <= 7'd17)      n = 5'd21;
      else if (t <= 7'd24) n = 5'd19;
      else if (t <= 7'd30) n = 5'd18;
      else if (t <= 7'd42) n = 5'd17;
    end else if (img == IMG_DOUBLE) begin
      if (t <= 7'd17)      n = 5'd21;
      else if (t <= 7'd24) n = 5'd19;
      else if (t <= 7'd30) n = 5'd18;
      else if (t <= 7'd35) n = 5'd17;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/zts_seq.sv
// Sequencer for the zoned translator: walks the track index one step a cycle.
// Depends on zts_pkg.
`default_nettype none

module zts_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [6:0]        n_steps_i,
  input  logic              out_free_i,
  output logic              in_ready_o,
  output zts_pkg::ctrl_t    ctrl_o
);

  zts_pkg::state_e state_q, state_d;
  logic [6:0] idx_q, idx_d;
  logic [6:0] n_steps_q, n_steps_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= zts_pkg::ST_IDLE;
      idx_q     <= 7'd1;
      n_steps_q <= 7'd0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      n_steps_q <= n_steps_d;
    end
  end

  always_comb begin
    idx_d     = idx_q;
    n_steps_d = n_steps_q;
    if (start_i) begin
      idx_d     = 7'd1;
      n_steps_d = n_steps_i;
    end else if (state_q == zts_pkg::ST_RUN) begin
      idx_d = idx_q + 7'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zts_pkg::ST_IDLE: begin
        if (start_i) state_d = (n_steps_i == 7'd0) ? zts_pkg::ST_FIN : zts_pkg::ST_RUN;
      end
      zts_pkg::ST_RUN: begin
        if (idx_q == n_steps_q) state_d = zts_pkg::ST_FIN;
      end
      zts_pkg::ST_FIN: begin
        if (out_free_i) state_d = zts_pkg::ST_IDLE;
      end
      default: state_d = zts_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    ctrl_o.start = start_i;
    ctrl_o.step  = 1'b0;
    ctrl_o.fin   = 1'b0;
    ctrl_o.idx   = idx_q;
    unique case (state_q)
      zts_pkg::ST_IDLE: in_ready_o  = 1'b1;
      zts_pkg::ST_RUN:  ctrl_o.step = 1'b1;
      zts_pkg::ST_FIN:  ctrl_o.fin  = out_free_i;
      default:          in_ready_o  = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/zts_acc.sv
// Shared accumulator of the zoned translator: running track start and match search.
// Depends on zts_pkg.
`default_nettype none

module zts_acc (
  input  logic              clk_i,
  input  zts_pkg::ctrl_t    ctrl_i,
  input  logic [1:0]        img_i,
  input  zts_pkg::in_t      item_i,
  input  logic              pre_bad_i,
  output zts_pkg::out_t     result_o
);

  logic [10:0] s_q, s_d;
  logic [6:0]  found_q, found_d;
  logic [10:0] fstart_q, fstart_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic [4:0]  step_cnt;
  logic [4:0]  trk_cnt;
  logic [10:0] diff;

  assign step_cnt = zts_pkg::sec_count(img_i, ctrl_i.idx);
  assign trk_cnt  = zts_pkg::sec_count(img_i, item_i.track_in);
  assign diff     = item_i.block_in - fstart_q;

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    found_q  <= found_d;
    fstart_q <= fstart_d;
    fcnt_q   <= fcnt_d;
  end

  always_comb begin
    s_d      = s_q;
    found_d  = found_q;
    fstart_d = fstart_q;
    fcnt_d   = fcnt_q;
    if (ctrl_i.start) begin
      s_d      = 11'd1;
      found_d  = 7'd0;
      fstart_d = 11'd1;
      fcnt_d   = 5'd0;
    end else if (ctrl_i.step) begin
      // remember the last track whose start is at or below the block
      if (s_q <= item_i.block_in) begin
        found_d  = ctrl_i.idx;
        fstart_d = s_q;
        fcnt_d   = step_cnt;
      end
      s_d = s_q + 11'(step_cnt);
    end
  end

  always_comb begin
    result_o             = '0;
    result_o.bad_address = 1'b1;
    if (!pre_bad_i) begin
      case (item_i.req_type)
        zts_pkg::REQ_FWD: begin
          if (item_i.sector_in < 8'(trk_cnt)) begin
            result_o.block_out   = s_q + 11'(item_i.sector_in);
            result_o.bad_address = 1'b0;
          end
        end
        zts_pkg::REQ_REV: begin
          if (found_q != 7'd0 && diff < 11'(fcnt_q)) begin
            result_o.track_out   = found_q;
            result_o.sector_out  = diff[4:0];
            result_o.bad_address = 1'b0;
          end
        end
        zts_pkg::REQ_CNT: begin
          result_o.sectors_on_track = trk_cnt;
          result_o.bad_address      = 1'b0;
        end
        default: result_o.bad_address = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/zoned_track_sector_lba_map_top.sv
// Zoned track/sector to block translator, top level. Uses zts_pkg, zts_seq, zts_acc.
// Operation: accept, then one sequencer step per track summed (track-1 for forward, last valid
// track count for reverse, none for a query or an error), then a finish state that waits
// for the output register to be free and loads the result word. One item is in work at a
// time; the single track-start adder serves it, and no new item is taken until it is done.
// Reset: image_type 1, max_tracks 35, sequencer idle, no result pending.
`default_nettype none

module zoned_track_sector_lba_map_top #(
  parameter int TRACK_LIMIT = 70
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  zts_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output zts_pkg::out_t     out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i
);

  logic [1:0]     image_type_q;
  logic [6:0]     max_tracks_q;
  zts_pkg::in_t   item_q;
  logic           pre_bad_q, pre_bad_d;
  zts_pkg::out_t  out_q;
  logic           out_valid_q;
  zts_pkg::out_t  result;
  zts_pkg::ctrl_t ctrl;
  logic           in_fire;
  logic           out_free;
  logic [6:0]     len, lim, last;
  logic [6:0]     n_steps;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_type_q <= zts_pkg::IMG_STD;
      max_tracks_q <= 7'd35;
    end else if (cfg_valid_i && cfg_index_i[1] == 1'b0) begin
      if (cfg_index_i[0] == zts_pkg::CFG_IMAGE_TYPE) image_type_q <= cfg_data_i[1:0];
      else if (cfg_index_i[0] == zts_pkg::CFG_MAX_TRACKS) max_tracks_q <= cfg_data_i;
    end
  end

  // highest valid track and loop length
  always_comb begin
    len  = zts_pkg::table_len(image_type_q);
    lim  = (max_tracks_q < len) ? max_tracks_q : len;
    last = (lim < 7'(TRACK_LIMIT)) ? lim : 7'(TRACK_LIMIT);
    pre_bad_d = 1'b0;
    n_steps   = 7'd0;
    case (in_data_i.req_type) inside
      zts_pkg::REQ_FWD, zts_pkg::REQ_CNT: begin
        pre_bad_d = (in_data_i.track_in == 7'd0) || (in_data_i.track_in > last);
        if (in_data_i.req_type == zts_pkg::REQ_FWD) n_steps = in_data_i.track_in - 7'd1;
      end
      zts_pkg::REQ_REV: begin
        pre_bad_d = (in_data_i.block_in == 11'd0) || (last == 7'd0);
        n_steps   = last;
      end
      default: pre_bad_d = 1'b1;
    endcase
    if (pre_bad_d) n_steps = 7'd0;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q    <= in_data_i;
      pre_bad_q <= pre_bad_d;
    end
    if (ctrl.fin) out_q <= result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  zts_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .n_steps_i  (n_steps),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  zts_acc u_acc (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .img_i     (image_type_q),
    .item_i    (item_q),
    .pre_bad_i (pre_bad_q),
    .result_o  (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_bad_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_address |-> out_data_o.block_out == 11'd0 &&
      out_data_o.track_out == 7'd0 && out_data_o.sector_out == 5'd0 &&
      out_data_o.sectors_on_track == 5'd0)
    else $error("error word carries nonzero fields");

  a_good_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bad_address |-> out_data_o.block_out != 11'd0 ||
      out_data_o.track_out != 7'd0 || out_data_o.sectors_on_track != 5'd0)
    else $error("good word carries no result");

endmodule

`default_nettype wire
